FILE: rtl/mbrc_pkg.sv
`default_nettype none

package mbrc_pkg;

    localparam logic [7:0] FUNC_READ_REGS = 8'h03;
    localparam logic [8:0] LEN_OVERHEAD   = 9'd5;
    localparam logic [8:0] DATA_START     = 9'd3;
    localparam logic [8:0] MIN_FRAME_LEN  = 9'd3;
    localparam logic [8:0] POS_MAX        = 9'd511;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FUNC_CODE = 3'd1;
    localparam logic [2:0] ST_BYTE_CNT  = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_CRC       = 3'd4;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic        kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // Modbus CRC-16, one byte, reflected polynomial.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mbrc_parser.sv
`default_nettype none

module mbrc_parser
    import mbrc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_count,
    input  wire logic       fire,
    input  wire logic [7:0] item_byte,
    input  wire logic       item_last,
    output logic            res_valid,
    output result_t         res
);

    logic [6:0]  expected_reg, expected_next;
    logic [8:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  ferr_reg, ferr_next;
    logic [7:0]  declared_reg, declared_next;
    logic [7:0]  held_reg, held_next;
    logic [6:0]  windex_reg, windex_next;
    logic [8:0]  len;
    logic [8:0]  data_off;
    logic        in_data;

    always_comb begin
        expected_next = cfg_we ? cfg_count : expected_reg;
        crc_next      = crc16_byte(crc_reg, item_byte);
        len           = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : POS_MAX;
        ferr_next     = ferr_reg;
        declared_next = declared_reg;
        held_next     = held_reg;
        windex_next   = windex_reg;
        pos_next      = len;
        data_off      = pos_reg - DATA_START;
        in_data       = (pos_reg >= DATA_START) && (data_off < {1'b0, declared_reg});
        res_valid     = 1'b0;
        res           = '0;

        if (pos_reg == 9'd1) begin
            if (item_byte != FUNC_READ_REGS && ferr_reg == ST_OK) begin
                ferr_next = ST_FUNC_CODE;
            end
        end else if (pos_reg == 9'd2) begin
            declared_next = item_byte;
            if (item_byte != {expected_reg, 1'b0} && ferr_reg == ST_OK) begin
                ferr_next = ST_BYTE_CNT;
            end
        end

        if (!item_last) begin
            if (in_data) begin
                if (!data_off[0]) begin
                    held_next = item_byte;
                end else begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_WORD;
                    res.reg_index = windex_reg;
                    res.reg_value = {held_reg, item_byte};
                    windex_next   = windex_reg + 7'd1;
                end
            end
        end else begin
            res_valid = 1'b1;
            res.kind  = KIND_STATUS;
            res.last  = 1'b1;
            if (len < MIN_FRAME_LEN) begin
                res.status = ST_LENGTH;
            end else if (ferr_next != ST_OK) begin
                res.status = ferr_next;
            end else if ({1'b0, declared_next} + LEN_OVERHEAD != len) begin
                res.status = ST_LENGTH;
            end else if (crc_next != 16'h0000) begin
                res.status = ST_CRC;
            end else begin
                res.status = ST_OK;
            end
            // The frame is done; start the next one from scratch.
            pos_next      = '0;
            crc_next      = CRC_INIT;
            ferr_next     = ST_OK;
            declared_next = '0;
            held_next     = '0;
            windex_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= 7'd1;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            ferr_reg     <= ST_OK;
            declared_reg <= '0;
            held_reg     <= '0;
            windex_reg   <= '0;
        end else begin
            expected_reg <= expected_next;
            if (fire) begin
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                ferr_reg     <= ferr_next;
                declared_reg <= declared_next;
                held_reg     <= held_next;
                windex_reg   <= windex_next;
            end
        end
    end

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item_last |=> pos_reg == '0 && crc_reg == CRC_INIT && ferr_reg == ST_OK)
        else $error("frame state not cleared after frame end");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item_last |=> pos_reg != '0)
        else $error("byte position did not advance");

    a_word_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && res.kind == KIND_WORD |-> !item_last && pos_reg >= DATA_START)
        else $error("word result outside the data area");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid |-> (res.kind == KIND_STATUS) == item_last)
        else $error("status result not tied to frame end");

endmodule

`default_nettype wire

FILE: rtl/mbrc_out_reg.sv
`default_nettype none

module mbrc_out_reg
    import mbrc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire logic  res_valid,
    input  wire result_t res,
    output logic       take,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [31:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // The register can take a new result when empty or being drained.
    assign take       = !valid_reg || m_tready;
    assign valid_next = take ? (fire && res_valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && fire && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, res_reg.status, res_reg.reg_value, res_reg.reg_index};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_tready |=> valid_reg && $stable(res_reg))
        else $error("pending result lost while stalled");

endmodule

`default_nettype wire

FILE: rtl/modbus_read_reply_checker.sv
// Modbus RTU read-registers reply checker.
// Input channel (s_): one frame byte per item in s_tdata, s_tlast set on the
// frame's last byte (the second CRC byte). Result channel (m_): each register
// word is sent as soon as its low byte arrives (m_tuser = 0); the last byte
// of a frame yields one status item (m_tuser = 1, m_tlast = 1) with codes
// 0 ok, 1 function code, 2 byte count, 3 length, 4 CRC error.
// Configuration: cfg_data sets the expected register count, written when
// cfg_valid is high; cfg_ready is always high. Write it only between frames.
// An accepted byte is held in an input register and processed once the result
// register can take what it produces; its result is then registered there,
// shows on m_tvalid from then on and stays until the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single-byte CRC update and the checks between the input and result registers.
// Reset clears all frame state, sets the expected count to 1 and empties both
// registers. When the receiver stalls, the pending result holds and the input
// register absorbs one more byte before s_tready drops.
`default_nettype none

module modbus_read_reply_checker
    import mbrc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [6:0] reg_index, [22:7] reg_value,
                                        // [25:23] status, [31:26] zero
    output logic             m_tuser,   // kind
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data   // expected_reg_count
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       take;
    logic       fire;
    logic       accept;
    logic       res_valid;
    result_t    res;

    // The byte in the input register is processed when the result register
    // can take whatever it produces.
    assign fire      = in_valid_reg && take;
    assign s_tready  = !in_valid_reg || take;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mbrc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_count (cfg_data),
        .fire      (fire),
        .item_byte (in_byte_reg),
        .item_last (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mbrc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !take |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input item dropped while stalled");

endmodule

`default_nettype wire

FILE: tb/modbus_read_reply_checker_tb.sv
`timescale 1ns / 1ps

import mbrc_pkg::*;

// Tracks one reply frame the way the parser should, and keeps the results
// that the parser still owes in arrival order.
class reply_tracker;
    logic [6:0]  reg_count;
    logic [8:0]  byte_pos;
    logic [15:0] crc;
    logic [2:0]  first_err;
    logic [7:0]  declared_cnt;
    logic [7:0]  high_byte;
    logic [6:0]  word_idx;
    result_t     results_due[$];
    int          failures;
    int          words_checked;
    int          status_hits[5];

    function new();
        reg_count     = 7'd1;
        failures      = 0;
        words_checked = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        byte_pos     = '0;
        crc          = CRC_INIT;
        first_err    = ST_OK;
        declared_cnt = '0;
        high_byte    = '0;
        word_idx     = '0;
    endfunction

    // Modbus CRC-16 over one byte, low bit first.
    static function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Called once per accepted input item.
    function void note_byte(input logic [7:0] b, input logic frame_end);
        logic [8:0] pos;
        logic [8:0] len;
        logic [8:0] offset;
        logic [2:0] st;
        result_t    r;
        pos      = byte_pos;
        crc      = crc_step(crc, b);
        len      = (pos < POS_MAX) ? pos + 9'd1 : POS_MAX;
        byte_pos = len;
        if (pos == 9'd1) begin
            if (b != FUNC_READ_REGS && first_err == ST_OK) first_err = ST_FUNC_CODE;
        end else if (pos == 9'd2) begin
            declared_cnt = b;
            if (b != {reg_count, 1'b0} && first_err == ST_OK) first_err = ST_BYTE_CNT;
        end
        if (!frame_end) begin
            offset = pos - DATA_START;
            if (pos >= DATA_START && offset < {1'b0, declared_cnt}) begin
                if (!offset[0]) begin
                    high_byte = b;
                end else begin
                    r = '{kind: KIND_WORD, reg_index: word_idx, reg_value: {high_byte, b},
                          status: ST_OK, last: 1'b0};
                    results_due.push_back(r);
                    word_idx = word_idx + 7'd1;
                end
            end
        end else begin
            if (len < MIN_FRAME_LEN) st = ST_LENGTH;
            else if (first_err != ST_OK) st = first_err;
            else if ({1'b0, declared_cnt} + LEN_OVERHEAD != len) st = ST_LENGTH;
            else if (crc != 16'h0000) st = ST_CRC;
            else st = ST_OK;
            r = '{kind: KIND_STATUS, reg_index: 7'd0, reg_value: 16'd0, status: st, last: 1'b1};
            results_due.push_back(r);
            restart_frame();
        end
    endfunction

    // Called once per accepted result item.
    function void check_item(input logic kind, input logic [6:0] idx, input logic [15:0] value,
                             input logic [2:0] st, input logic last);
        result_t want;
        if (results_due.size() == 0) begin
            failures++;
            $error("unexpected result: kind %0d index %0d value %h status %0d",
                   kind, idx, value, st);
            return;
        end
        want = results_due.pop_front();
        if (kind !== want.kind) begin
            failures++;
            $error("kind: expected %0d, got %0d", want.kind, kind);
        end
        if (idx !== want.reg_index) begin
            failures++;
            $error("reg_index: expected %0d, got %0d", want.reg_index, idx);
        end
        if (value !== want.reg_value) begin
            failures++;
            $error("reg_value: expected %h, got %h", want.reg_value, value);
        end
        if (st !== want.status) begin
            failures++;
            $error("status: expected %0d, got %0d", want.status, st);
        end
        if (last !== want.last) begin
            failures++;
            $error("last: expected %0d, got %0d", want.last, last);
        end
        if (want.kind == KIND_STATUS) status_hits[want.status]++;
        else words_checked++;
    endfunction
endclass

module modbus_read_reply_checker_tb;

    // Cycles without any handshake on any channel before the run is declared hung.
    // The longest legal quiet stretch is a sender gap or a short pause before a
    // register write, so this is many times what a correct run ever needs.
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_BYTES = 1300;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [6:0]  cfg_data  = 7'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;     // [6:0] reg_index, [22:7] reg_value, [25:23] status
    logic        m_tuser;     // kind
    logic        m_tlast;     // last
    logic        cfg_ready;

    reply_tracker tracker = new();

    // The frame being assembled before it goes out, byte 0 first.
    logic [7:0] frame_buf[$];

    int burst_left    = 0;
    int idle_cycles   = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 0;
    int rx_mode       = 0;
    int rx_mode_left  = 0;

    modbus_read_reply_checker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver back-pressure. After a randomly drawn stretch the receiver switches
    // to a new behavior: always ready, a coin toss, mostly stalled, or mostly ready.
    // The always-ready stretches give runs with no stall at all.
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(8, 96);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    // Result monitor and watchdog. Everything is sampled right at the rising
    // edge, before any register in the block or in this bench updates, so the
    // values seen are the ones the handshake was decided on.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_item(m_tuser, m_tdata[6:0], m_tdata[22:7], m_tdata[25:23],
                                   m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("No handshake for %0d cycles, %0d results still owed.",
                             IDLE_LIMIT, tracker.results_due.size());
                    $display("modbus_read_reply_checker: mismatch");
                    $finish;
                end
            end
        end
    end

    // Offers one byte and waits for it to be taken. The sender works in bursts:
    // when a burst runs out, valid drops for a random gap and a new burst length
    // is drawn. Now and then a burst is long, which gives stretches without gaps.
    task automatic send_byte(input logic [7:0] b, input logic frame_end);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= frame_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_byte(b, frame_end);
        bytes_sent++;
    endtask

    // Sends the assembled frame, flagging its final byte as the frame end.
    task automatic send_frame();
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_sent++;
    endtask

    // Address, function code, byte count and the data area. The data area
    // is random, all zeros or all ones depending on fill.
    task automatic build_body(input logic [7:0] addr, input logic [7:0] count_byte,
                              input int fill);
        frame_buf = {};
        frame_buf.push_back(addr);
        frame_buf.push_back(FUNC_READ_REGS);
        frame_buf.push_back(count_byte);
        repeat (count_byte) begin
            case (fill)
                1: begin
                    frame_buf.push_back(8'h00);
                end
                2: begin
                    frame_buf.push_back(8'hFF);
                end
                default: begin
                    frame_buf.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Appends the CRC, low byte first, so the whole frame leaves a zero residue.
    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i]) c = tracker.crc_step(c, frame_buf[i]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic build_noise(input int n_bytes);
        frame_buf = {};
        repeat (n_bytes) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // The count register may only change between frames with the parser idle:
    // all owed results in, then a wait for any byte that produced none to drain
    // through the two pipeline stages.
    task automatic write_reg_count(input logic [6:0] value);
        s_tvalid <= 1'b0;
        while (tracker.results_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.reg_count = value;
        settings_used++;
    endtask

    // One frame of the random part. Most are well-formed replies for the
    // current count with random content; the rest carry one kind of damage.
    task automatic send_random_frame(input logic [6:0] n_regs);
        int          pick;
        int          k;
        int          alt_cnt;
        logic [7:0]  cnt;
        cnt  = {n_regs, 1'b0};
        pick = $urandom_range(0, 15);
        if (pick <= 8) begin
            build_body(8'($urandom_range(0, 255)), cnt, 0);
            append_crc();
        end else if (pick == 9) begin
            // Wrong function code, everything else consistent.
            build_body(8'($urandom_range(0, 255)), cnt, 0);
            frame_buf[1] = FUNC_READ_REGS ^ 8'($urandom_range(1, 255));
            append_crc();
        end else if (pick == 10) begin
            // Byte count that disagrees with the register count; odd counts
            // leave a trailing data byte that never forms a word.
            alt_cnt = $urandom_range(0, cnt + 6);
            if (alt_cnt > 255) alt_cnt = 255;
            if (alt_cnt == cnt) alt_cnt = cnt ^ 1;
            build_body(8'($urandom_range(0, 255)), 8'(alt_cnt), 0);
            append_crc();
        end else if (pick == 11) begin
            // One corrupted byte in the data or CRC area.
            build_body(8'($urandom_range(0, 255)), cnt, 0);
            append_crc();
            k = $urandom_range(3, frame_buf.size() - 1);
            frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
        end else if (pick == 12) begin
            // Cut short somewhere.
            build_body(8'($urandom_range(0, 255)), cnt, 0);
            append_crc();
            repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
        end else if (pick == 13) begin
            // Trailing junk after a good reply.
            build_body(8'($urandom_range(0, 255)), cnt, 0);
            append_crc();
            repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end else if (pick == 14) begin
            build_noise($urandom_range(1, 2));
        end else begin
            build_noise($urandom_range(1, 12));
        end
        send_frame();
    endtask

    initial begin
        int         target;
        int         n_frames;
        int         sel;
        logic [6:0] n_regs;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at the reset count of one register.
        // Good reply, address and data all zeros.
        build_body(8'h00, 8'd2, 1);
        append_crc();
        send_frame();
        // Good reply, address and data all ones.
        build_body(8'hFF, 8'd2, 2);
        append_crc();
        send_frame();
        // Short frames of one and two bytes, and a three-byte frame.
        build_noise(1);
        frame_buf[0] = 8'hFF;
        send_frame();
        build_noise(2);
        send_frame();
        frame_buf = {8'h11, FUNC_READ_REGS, 8'h00};
        send_frame();
        // Wrong function code.
        build_body(8'h01, 8'd2, 0);
        frame_buf[1] = 8'h04;
        append_crc();
        send_frame();
        // Odd byte count: one word, then a lone data byte.
        build_body(8'h01, 8'd3, 0);
        append_crc();
        send_frame();
        // One byte too long.
        build_body(8'h01, 8'd2, 0);
        append_crc();
        frame_buf.push_back(8'h5A);
        send_frame();
        // Corrupted CRC.
        build_body(8'h01, 8'd2, 0);
        append_crc();
        frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h80;
        send_frame();
        // Frame long enough to saturate the byte position.
        build_body(8'h01, 8'd2, 0);
        append_crc();
        while (frame_buf.size() < 520) frame_buf.push_back(8'($urandom_range(0, 255)));
        send_frame();

        // Zero registers: a bare five-byte reply.
        write_reg_count(7'd0);
        build_body(8'h22, 8'd0, 0);
        append_crc();
        send_frame();
        // Out-of-range count: a two-register reply no longer matches.
        write_reg_count(7'd127);
        build_body(8'h22, 8'd4, 0);
        append_crc();
        send_frame();

        // Random phases. Each phase writes the count, then sends a few frames.
        // Counts are mostly small; now and then the largest legal count, one
        // of the two out-of-range values, or anything the register holds.
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            sel = $urandom_range(0, 39);
            if (sel == 0) n_regs = 7'd125;
            else if (sel == 1) n_regs = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd126;
            else if (sel <= 4) n_regs = 7'($urandom_range(0, 127));
            else n_regs = 7'($urandom_range(0, 6));
            write_reg_count(n_regs);
            n_frames = (n_regs > 7'd16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
            repeat (n_frames) send_random_frame(n_regs);
        end

        // Drain: everything owed, then an extra wait for anything unexpected.
        s_tvalid <= 1'b0;
        while (tracker.results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d frames (%0d bytes) under %0d count settings; %0d words checked.",
                 frames_sent, bytes_sent, settings_used, tracker.words_checked);
        $display("Frame status seen: ok %0d, function %0d, byte count %0d, length %0d, crc %0d.",
                 tracker.status_hits[ST_OK], tracker.status_hits[ST_FUNC_CODE],
                 tracker.status_hits[ST_BYTE_CNT], tracker.status_hits[ST_LENGTH],
                 tracker.status_hits[ST_CRC]);
        if (tracker.failures == 0 && tracker.results_due.size() == 0) begin
            $display("modbus_read_reply_checker: match");
        end else begin
            $display("modbus_read_reply_checker: mismatch");
        end
        $finish;
    end

endmodule
